>>> rtl/gapr_pkg.sv
// Package with shared types and codes of the population replace and roulette block.
package gapr_pkg;

  localparam int unsigned OpW = 2;
  localparam int unsigned TagW = 16;
  localparam int unsigned FitW = 32;
  localparam int unsigned StatW = 3;
  localparam int unsigned PosW = 7;

  localparam logic [OpW-1:0] OpLoad  = 2'd0;
  localparam logic [OpW-1:0] OpOffer = 2'd1;
  localparam logic [OpW-1:0] OpDraw  = 2'd2;
  localparam logic [OpW-1:0] OpNone  = 2'd3;

  localparam logic [StatW-1:0] StLoaded   = 3'd0;
  localparam logic [StatW-1:0] StReplaced = 3'd1;
  localparam logic [StatW-1:0] StNotBet   = 3'd2;
  localparam logic [StatW-1:0] StStagn    = 3'd3;
  localparam logic [StatW-1:0] StDrawn    = 3'd4;
  localparam logic [StatW-1:0] StError    = 3'd5;

  localparam logic [1:0] CfgMinimize = 2'd0;
  localparam logic [1:0] CfgRepMode  = 2'd1;
  localparam logic [1:0] CfgPrevStag = 2'd2;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [PosW-1:0]  position;
    logic [TagW-1:0]  tag;
    logic [FitW-1:0]  fitness;
  } result_t;

endpackage

>>> rtl/ga_population_replace_and_roulette.sv
// Top level: sorted population store with load, steady-state offer and roulette draw.
//
// Channel   Dir  Payload
// s_axis    in   tdata: opcode, entry_tag, entry_fitness, random_fraction, same_as_best
// m_axis    out  tdata: status, position, result_tag, result_fitness
// cfg       in   cfg_index_i register index, cfg_data_i write data
//
// One item at a time. A load writes the entry behind the last one, then moves it toward
// index 0 while it is larger than its neighbour. A draw or a roulette offer sums all
// weights (through a serial divider per entry in inverse mode), multiplies in 3 steps,
// then rescans the same way.
// Each entry move reads, compares and swaps on a store with one read and one write port.
// Reset empties the population at once; s_axis_tready stays low until the result item is taken.
module ga_population_replace_and_roulette #(
  parameter int unsigned POP_SIZE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], entry_tag[17:2], entry_fitness[49:18], random_fraction[81:50],
  // same_as_best[82], zero fill up to bit 87
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], position[9:3], result_tag[25:10], result_fitness[57:26],
  // zero fill up to bit 63
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import gapr_pkg::*;

  localparam int unsigned AW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
  localparam int unsigned CW = $clog2(POP_SIZE + 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DECODE = 16'h0002,
    S_SUMRD  = 16'h0004,
    S_SUMW   = 16'h0008,
    S_DIV    = 16'h0010,
    S_MUL    = 16'h0020,
    S_VICRD  = 16'h0040,
    S_VICCHK = 16'h0080,
    S_SETRD  = 16'h0100,
    S_SETCMP = 16'h0200,
    S_SWAPW  = 16'h0400,
    S_DONE   = 16'h0800,
    S_OUT    = 16'h1000,
    S_RD0    = 16'h2000,
    S_BESTRD = 16'h4000,
    S_DRAWRD = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [FitW-1:0] fit_mem [POP_SIZE];
  logic [TagW-1:0] tag_mem [POP_SIZE];
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [FitW-1:0] wfit, rfit_q;
  logic [TagW-1:0] wtag, rtag_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      fit_mem[waddr] <= wfit;
      tag_mem[waddr] <= wtag;
    end
    rfit_q <= fit_mem[raddr];
    rtag_q <= tag_mem[raddr];
  end

  logic            min_q, rep_q, stag_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [OpW-1:0]  op_q, op_d;
  logic [TagW-1:0] itag_q, itag_d;
  logic [FitW-1:0] ifit_q, ifit_d;
  logic [31:0]     r_q, r_d;
  logic            same_q, same_d;
  logic            pass_q, pass_d;      // 0 summing, 1 scanning
  logic            inv_q, inv_d;
  logic            isoff_q, isoff_d;    // roulette serves an offer
  logic [AW-1:0]   idx_q, idx_d;
  logic [FitW-1:0] f0_q, f0_d;
  logic [FitW+AW:0] tot_q, tot_d, acc_q, acc_d;
  logic [63:0]     score_q, score_d;
  logic [1:0]      mstep_q, mstep_d;
  logic [47:0]     num_q, num_d;
  logic [48:0]     rem_q, rem_d;
  logic [5:0]      dcnt_q, dcnt_d;
  logic [FitW-1:0] div_q, div_d;
  logic [FitW-1:0] cf_q, cf_d;         // moving entry
  logic [TagW-1:0] ct_q, ct_d;
  logic [FitW-1:0] nf_q, nf_d;         // neighbour
  logic [TagW-1:0] nt_q, nt_d;
  logic            up_q, up_d, dirset_q, dirset_d;
  logic [AW-1:0]   pos_q, pos_d;
  result_t         res_q, res_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, res_q.fitness, res_q.tag, res_q.position, res_q.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= 1'b0;
      rep_q  <= 1'b0;
      stag_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinimize: min_q  <= cfg_data_i[0];
        CfgRepMode:  rep_q  <= cfg_data_i[0];
        CfgPrevStag: stag_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [49:0] sub;
  logic [63:0] pp;
  logic [CW-1:0] last;
  logic [AW-1:0] lastw;
  logic [FitW-1:0] wgt;
  assign last  = cnt_q - CW'(1);
  assign lastw = last[AW-1:0];
  assign sub   = {rem_q, num_q[47]} - {18'd0, div_q};

  always_comb begin
    case (mstep_q)
      2'd0:    pp = 64'(tot_q[15:0]) * 64'(r_q);
      2'd1:    pp = 64'(tot_q[31:16]) * 64'(r_q);
      2'd2:    pp = 64'(tot_q[FitW+AW:32]) * 64'(r_q);
      default: pp = '0;
    endcase
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; op_d = op_q; itag_d = itag_q; ifit_d = ifit_q;
    r_d = r_q; same_d = same_q; pass_d = pass_q; inv_d = inv_q; isoff_d = isoff_q;
    idx_d = idx_q; f0_d = f0_q; tot_d = tot_q; acc_d = acc_q; score_d = score_q;
    mstep_d = mstep_q; num_d = num_q; rem_d = rem_q; dcnt_d = dcnt_q; div_d = div_q;
    cf_d = cf_q; ct_d = ct_q; nf_d = nf_q; nt_d = nt_q; up_d = up_q;
    dirset_d = dirset_q; pos_d = pos_q; res_d = res_q;
    we = 1'b0; waddr = pos_q; wfit = cf_q; wtag = ct_q; raddr = idx_q;
    wgt = rfit_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d   = s_axis_tdata[1:0];
          itag_d = s_axis_tdata[17:2];
          ifit_d = s_axis_tdata[49:18];
          r_d    = s_axis_tdata[81:50];
          same_d = s_axis_tdata[82];
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d.status = StError; res_d.position = '0;
        res_d.tag = itag_q; res_d.fitness = ifit_q;
        dirset_d = 1'b0;
        state_d = S_OUT;
        if (op_q == OpLoad) begin
          if (cnt_q < CW'(POP_SIZE)) begin
            we = 1'b1; waddr = cnt_q[AW-1:0]; wfit = ifit_q; wtag = itag_q;
            cf_d = ifit_q; ct_d = itag_q; pos_d = cnt_q[AW-1:0];
            cnt_d = cnt_q + CW'(1);
            res_d.status = StLoaded;
            up_d = 1'b1; dirset_d = 1'b1;
            state_d = S_SETRD;
          end
        end else if (op_q == OpOffer || op_q == OpDraw) begin
          if (cnt_q != '0) begin
            isoff_d = (op_q == OpOffer);
            if (op_q == OpOffer && !rep_q) begin
              idx_d = min_q ? '0 : lastw;
              state_d = S_VICRD;
            end else begin
              inv_d = (op_q == OpOffer) ? !min_q : min_q;
              idx_d = '0; pass_d = 1'b0; tot_d = '0; acc_d = '0;
              state_d = S_RD0;
            end
          end
        end
      end
      S_RD0: begin
        raddr = '0;
        state_d = S_SUMRD;
      end
      S_SUMRD: begin
        if (idx_q == '0 && pass_q == 1'b0 && acc_q == '0) f0_d = rfit_q;
        if (inv_q) begin
          if (rfit_q == '0) state_d = S_SUMW;
          else begin
            num_d = {(idx_q == '0 && !pass_q) ? rfit_q : f0_q, 16'd0};
            rem_d = '0; div_d = rfit_q; dcnt_d = 6'd48;
            state_d = S_DIV;
          end
        end else state_d = S_SUMW;
      end
      S_DIV: begin
        if (!sub[49]) rem_d = sub[48:0];
        else rem_d = {rem_q[47:0], num_q[47]};
        num_d = {num_q[46:0], !sub[49]};
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) state_d = S_SUMW;
      end
      S_SUMW: begin
        if (inv_q)
          wgt = (rfit_q == '0 || num_q[47:32] != '0) ? '1 : num_q[31:0];
        if (!pass_q) begin
          tot_d = tot_q + (FitW+AW+1)'(wgt);
          if (CW'(idx_q) == last) begin
            score_d = '0; mstep_d = '0;
            state_d = S_MUL;
          end else begin
            idx_d = idx_q + AW'(1); state_d = S_SUMRD;
          end
          raddr = idx_d;
        end else begin
          acc_d = acc_q + (FitW+AW+1)'(wgt);
          if (score_q < 64'(acc_d)) begin
            state_d = S_DRAWRD;
          end else if (CW'(idx_q) == last) begin
            idx_d = '0; state_d = S_DRAWRD;
          end else begin
            idx_d = idx_q + AW'(1); state_d = S_SUMRD;
          end
          raddr = idx_d;
        end
      end
      S_MUL: begin
        case (mstep_q)
          2'd0: score_d = pp;
          2'd1: score_d = (score_q + (pp << 16)) >> 32;
          default: score_d = score_q + pp;
        endcase
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd2) begin
          pass_d = 1'b1; idx_d = '0; state_d = S_SUMRD;
        end
        raddr = '0;
      end
      S_DRAWRD: begin
        raddr = idx_q;
        if (isoff_q) state_d = S_VICCHK;
        else begin
          res_d.status = StDrawn; res_d.position = PosW'(idx_q);
          res_d.tag = rtag_q; res_d.fitness = rfit_q;
          state_d = S_OUT;
        end
      end
      S_VICRD: begin
        raddr = idx_q;
        state_d = S_VICCHK;
      end
      S_VICCHK: begin
        res_d.position = PosW'(idx_q);
        if (!(min_q ? (rfit_q > ifit_q) : (rfit_q < ifit_q))) begin
          res_d.status = StNotBet; state_d = S_OUT;
        end else begin
          nf_d = rfit_q; nt_d = rtag_q;
          raddr = min_q ? lastw : '0;
          state_d = S_BESTRD;
        end
      end
      S_BESTRD: begin
        if (stag_q && (ifit_q == rfit_q || same_q)) begin
          res_d.status = StStagn; state_d = S_OUT;
        end else begin
          res_d.status = StReplaced; res_d.tag = nt_q; res_d.fitness = nf_q;
          we = 1'b1; waddr = idx_q; wfit = ifit_q; wtag = itag_q;
          cf_d = ifit_q; ct_d = itag_q; pos_d = idx_q;
          state_d = S_SETRD;
        end
      end
      S_SETRD: begin
        if (!dirset_q) begin
          if (CW'(pos_q) + CW'(1) >= cnt_q) begin
            up_d = 1'b1; dirset_d = 1'b1;
            raddr = pos_q - AW'(1);
          end else raddr = pos_q + AW'(1);
        end else if (up_q) raddr = pos_q - AW'(1);
        else raddr = pos_q + AW'(1);
        if (dirset_d && up_d && pos_q == '0) state_d = S_DONE;
        else if (dirset_d && !up_d && CW'(pos_q) + CW'(1) >= cnt_q) state_d = S_DONE;
        else state_d = S_SETCMP;
      end
      S_SETCMP: begin
        nf_d = rfit_q; nt_d = rtag_q;
        if (!dirset_q) begin
          dirset_d = 1'b1;
          if (cf_q > rfit_q) begin
            up_d = 1'b1; state_d = S_SETRD;
          end else begin
            up_d = 1'b0;
            state_d = (cf_q < rfit_q) ? S_SWAPW : S_DONE;
          end
        end else if (up_q ? (cf_q > rfit_q) : (cf_q < rfit_q)) state_d = S_SWAPW;
        else state_d = S_DONE;
      end
      S_SWAPW: begin
        we = 1'b1; waddr = pos_q; wfit = nf_q; wtag = nt_q;
        pos_d = up_q ? pos_q - AW'(1) : pos_q + AW'(1);
        state_d = S_SETRD;
      end
      S_DONE: begin
        we = 1'b1; waddr = pos_q; wfit = cf_q; wtag = ct_q;
        res_d.position = PosW'(pos_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; itag_q <= itag_d; ifit_q <= ifit_d; r_q <= r_d; same_q <= same_d;
    pass_q <= pass_d; inv_q <= inv_d; isoff_q <= isoff_d; idx_q <= idx_d; f0_q <= f0_d;
    tot_q <= tot_d; acc_q <= acc_d; score_q <= score_d; mstep_q <= mstep_d;
    num_q <= num_d; rem_q <= rem_d; dcnt_q <= dcnt_d; div_q <= div_d;
    cf_q <= cf_d; ct_q <= ct_d; nf_q <= nf_d; nt_q <= nt_d; up_q <= up_d;
    dirset_q <= dirset_d; pos_q <= pos_d; res_q <= res_d;
  end

endmodule
